### design/olir_pkg.sv
// Package: widths, mode and status codes, and the cell command type for the ordered list.
package olir_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 4;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int VAL_W    = 32;
    localparam int COUNT_W  = 5;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_DROP   = 3'd3,
        MODE_CLEAR  = 3'd4,
        MODE_READ   = 3'd5
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic                    app;
        logic [CMP_W-1:0]        pos;
        logic [CMP_W-1:0]        cnt;
        logic signed [VAL_W-1:0] val;
    } cell_cmd_t;

endpackage

### design/olir_cell.sv
// One list entry: loads a new element or takes a neighbor's entry on insert and remove.
module olir_cell import olir_pkg::*; (
    input  logic                    aclk,
    input  cell_cmd_t               cmd,
    input  logic [CMP_W-1:0]        cell_idx,
    input  logic signed [VAL_W-1:0] left_data,
    input  logic signed [VAL_W-1:0] right_data,
    output logic signed [VAL_W-1:0] data
);

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        priority if (cmd.ins) begin
            if (cell_idx == cmd.pos) begin
                data_next = cmd.val;
            end else if (cell_idx > cmd.pos) begin
                data_next = left_data;
            end
        end else if (cmd.rem) begin
            if (cell_idx >= cmd.pos) begin
                data_next = right_data;
            end
        end else if (cmd.app) begin
            if (cell_idx == cmd.cnt) begin
                data_next = cmd.val;
            end
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### design/ordered_list_insert_remove.sv
// Top level: ordered list of signed elements held in a chain of entry cells.
// A result is registered in the cycle after its input transfer. One item per
// cycle is taken unless a result is held; on insert or remove, cells at or past
// the position update together. The read port is a single select over the cell outputs.
// Reset (aresetn low, synchronous) empties the list and the result register;
// entry contents are not cleared.
module ordered_list_insert_remove import olir_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // element_value[31:0], position[35:32], zero pad
    input  logic [MODE_W-1:0]   s_tuser,  // mode[2:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // count[4:0], read_value[36:5], zero pad
    output logic [STAT_W-1:0]   m_tuser   // status[1:0]
);

    logic                    accept;
    logic signed [VAL_W-1:0] in_val;
    logic [CMP_W-1:0]        pos_cmp;
    logic [CMP_W-1:0]        cnt_cmp;
    logic                    in_range;
    logic                    full;

    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    m_valid_reg;
    status_t                 status_reg;
    status_t                 status_next;
    logic signed [VAL_W-1:0] rd_reg;
    logic signed [VAL_W-1:0] rd_next;
    logic                    do_ins;
    logic                    do_rem;
    logic                    do_app;
    cell_cmd_t               cmd;

    logic signed [VAL_W-1:0] store [CAPACITY];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign in_val   = s_tdata[VAL_W-1:0];
    assign pos_cmp  = CMP_W'(s_tdata[VAL_W +: POS_W]);
    assign cnt_cmp  = CMP_W'(cnt_reg);
    assign in_range = pos_cmp < cnt_cmp;
    assign full     = cnt_reg == CNT_W'(CAPACITY);

    always_comb begin
        status_next = ST_OK;
        cnt_next    = cnt_reg;
        rd_next     = '0;
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        do_app      = 1'b0;
        unique case (s_tuser)
            MODE_APPEND: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    do_app   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            MODE_INSERT: begin
                if (!in_range) begin
                    status_next = ST_RANGE;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    do_ins   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (!in_range) begin
                    status_next = ST_RANGE;
                end else begin
                    do_rem   = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            MODE_DROP: begin
                if (cnt_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            MODE_CLEAR: begin
                cnt_next = '0;
            end
            MODE_READ: begin
                if (!in_range) begin
                    status_next = ST_RANGE;
                end else begin
                    rd_next = store[pos_cmp[IDX_W-1:0]];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        cmd.ins = accept && do_ins;
        cmd.rem = accept && do_rem;
        cmd.app = accept && do_app;
        cmd.pos = pos_cmp;
        cmd.cnt = cnt_cmp;
        cmd.val = in_val;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] left_d;
        logic signed [VAL_W-1:0] right_d;
        if (g == 0) begin : g_first
            assign left_d = in_val;
        end else begin : g_mid_l
            assign left_d = store[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_d = store[g];
        end else begin : g_mid_r
            assign right_d = store[g+1];
        end
        olir_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .cell_idx   (CMP_W'(g)),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (store[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cnt_reg     <= cnt_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            rd_reg     <= rd_next;
        end
    end

    logic [CNT_W-1:0] cnt_out_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            cnt_out_reg <= cnt_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(M_DATA_W - VAL_W - COUNT_W){1'b0}}, rd_reg, COUNT_W'(cnt_out_reg)};

endmodule

### design/olir_checker.sv
// Port checker for the ordered list, bound to the top level.
module olir_checker import olir_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic [MODE_W-1:0]   s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0]   m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == MODE_CLEAR
        |=> m_tvalid && m_tuser == ST_OK && m_tdata[COUNT_W-1:0] == '0)
        else $error("clear transfer did not give an empty list");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_FULL |-> m_tdata[COUNT_W-1:0] == COUNT_W'(CAPACITY))
        else $error("full status with count below capacity");

    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[COUNT_W +: VAL_W] == '0)
        else $error("read value nonzero on failed transfer");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !s_tvalid |=> !m_tvalid)
        else $error("result repeated after its transfer");

endmodule

bind ordered_list_insert_remove olir_checker u_olir_checker (.*);

### tb/list_result_checker.sv
// Checker for the ordered list: tracks the list, predicts each result and compares it.
module list_result_checker import olir_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // element_value[31:0], position[35:32], zero pad
    input  logic [MODE_W-1:0]   s_tuser,  // mode[2:0]
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,  // count[4:0], read_value[36:5], zero pad
    input  logic [STAT_W-1:0]   m_tuser,  // status[1:0]
    output int                  fail_count,
    output int                  pending,
    output int                  shadow_count
);

    typedef struct packed {
        status_t                 status;
        logic [COUNT_W-1:0]      count;
        logic signed [VAL_W-1:0] read_value;
    } list_outcome_t;

    logic signed [VAL_W-1:0] entry_mem [CAPACITY];
    list_outcome_t           outcome_q [$];

    initial begin
        fail_count   = 0;
        pending      = 0;
        shadow_count = 0;
    end

    function automatic list_outcome_t apply_list_op(logic [MODE_W-1:0] op,
                                                    logic signed [VAL_W-1:0] val,
                                                    logic [POS_W-1:0] pos);
        list_outcome_t r;
        int            i;
        r.status     = ST_OK;
        r.read_value = '0;
        case (op)
            MODE_APPEND: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    entry_mem[shadow_count] = val;
                    shadow_count++;
                end
            end
            MODE_INSERT: begin
                if (pos >= shadow_count) begin
                    r.status = ST_RANGE;
                end else if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = shadow_count; i > pos; i--)
                        entry_mem[i] = entry_mem[i-1];
                    entry_mem[pos] = val;
                    shadow_count++;
                end
            end
            MODE_REMOVE: begin
                if (pos >= shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = pos; i + 1 < shadow_count; i++)
                        entry_mem[i] = entry_mem[i+1];
                    shadow_count--;
                end
            end
            MODE_DROP: begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                    shadow_count--;
            end
            MODE_CLEAR: begin
                shadow_count = 0;
            end
            MODE_READ: begin
                if (pos >= shadow_count)
                    r.status = ST_RANGE;
                else
                    r.read_value = entry_mem[pos];
            end
            default: begin
            end
        endcase
        r.count = shadow_count[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        list_outcome_t want;
        list_outcome_t got;
        if (!aresetn) begin
            outcome_q.delete();
            shadow_count = 0;
        end else begin
            // retire before predicting: a result never leaves in its own input cycle
            if (m_tvalid && m_tready) begin
                got.status     = status_t'(m_tuser);
                got.count      = m_tdata[COUNT_W-1:0];
                got.read_value = m_tdata[COUNT_W+VAL_W-1:COUNT_W];
                if (outcome_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: status=%0d count=%0d value=%0d",
                                 got.status, got.count, got.read_value);
                end else begin
                    want = outcome_q.pop_front();
                    if (got.status !== want.status || got.count !== want.count ||
                        got.read_value !== want.read_value) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected status=%0d count=%0d value=%0d, %s",
                                     want.status, want.count, want.read_value,
                                     $sformatf("got status=%0d count=%0d value=%0d",
                                               got.status, got.count, got.read_value));
                    end
                end
            end
            if (s_tvalid && s_tready)
                outcome_q.insert(outcome_q.size(),
                                 apply_list_op(s_tuser, s_tdata[VAL_W-1:0],
                                               s_tdata[VAL_W+POS_W-1:VAL_W]));
        end
        pending = outcome_q.size();
    end

endmodule

### tb/tb_ordered_list_insert_remove.sv
// Testbench top for the ordered list: clock, reset, stimulus, result stalls and verdict.
module tb_ordered_list_insert_remove;
    import olir_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
    localparam int                RANDOM_OPS   = 1250;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;  // element_value[31:0], position[35:32], zero pad
    logic [MODE_W-1:0]   s_tuser  = '0;  // mode[2:0]
    logic                m_tvalid;
    logic                m_tready = 1'b1;
    logic [M_DATA_W-1:0] m_tdata;        // count[4:0], read_value[36:5], zero pad
    logic [STAT_W-1:0]   m_tuser;        // status[1:0]

    int fail_count;
    int pending;
    int shadow_count;
    int stall_left = 0;
    bit calm       = 1'b0;

    ordered_list_insert_remove dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    list_result_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .shadow_count (shadow_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    always @(negedge aclk) begin
        int n;
        if (calm || !aresetn) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < 70) begin
            m_tready <= 1'b1;
        end else begin
            n = pick_gap();
            if (n == 0)
                n = 1;
            m_tready   <= 1'b0;
            stall_left = n - 1;
        end
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        if (shadow_count > 0)
            return POS_W'($urandom_range(0, shadow_count - 1));
        return POS_W'($urandom_range(0, 15));
    endfunction

    task automatic push_op(logic [MODE_W-1:0] op, logic signed [VAL_W-1:0] val,
                           logic [POS_W-1:0] pos);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_DATA_W-VAL_W-POS_W){1'b0}}, pos, val};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic pace();
        int g;
        g = calm ? 0 : pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge aclk);
        while (pending != 0);
    endtask

    initial begin
        int  issued;
        int  r;
        bit  grow;
        logic [MODE_W-1:0] op;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty list corner cases, then directed appends, inserts, reads, removes, spare modes and clears
        push_op(MODE_READ,   32'sd5, 4'd0);
        push_op(MODE_DROP,   32'sd0, 4'd0);
        push_op(MODE_REMOVE, 32'sd0, 4'd0);
        push_op(MODE_INSERT, 32'sd9, 4'd0);
        push_op(MODE_READ,   32'sd0, 4'd15);
        pace();
        push_op(MODE_APPEND, 32'sh7fff_ffff, 4'd15);
        push_op(MODE_APPEND, 32'sh8000_0000, 4'd0);
        push_op(MODE_INSERT, 32'sd1, 4'd2);
        push_op(MODE_INSERT, -32'sd1, 4'd0);
        push_op(MODE_INSERT, 32'sh5a5a_a5a5, 4'd2);
        push_op(MODE_READ,   32'sd0, 4'd0);
        push_op(MODE_READ,   32'sd0, 4'd3);
        push_op(MODE_READ,   32'sd0, 4'd4);
        pace();
        push_op(MODE_REMOVE, 32'sd0, 4'd1);
        push_op(MODE_REMOVE, 32'sd0, 4'd3);
        push_op(MODE_READ,   32'sd0, 4'd1);
        push_op(MODE_SPARE_A, 32'sd7, 4'd0);
        push_op(MODE_SPARE_B, 32'sd7, 4'd1);
        push_op(MODE_DROP,   32'sd0, 4'd0);
        push_op(MODE_CLEAR,  32'sd0, 4'd0);
        push_op(MODE_READ,   32'sd0, 4'd0);
        push_op(MODE_CLEAR,  32'sd0, 4'd0);
        drain();

        // grow toward full, then shrink toward empty, with valid positions mostly
        grow   = 1'b1;
        issued = 0;
        while (issued < RANDOM_OPS) begin
            calm = (issued >= 200 && issued < 350);
            if (issued == 600)
                drain();
            pace();
            if (shadow_count >= CAPACITY)
                grow = 1'b0;
            else if (shadow_count == 0)
                grow = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 1) begin
                push_op($urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B,
                        $urandom(), POS_W'($urandom_range(0, 15)));
                continue;
            end
            if (r < 3) begin
                op = MODE_CLEAR;
            end else if (r < 8) begin
                op = $urandom_range(0, 1) ? MODE_READ : MODE_REMOVE;
                push_op(op, pick_value(), POS_W'($urandom_range(0, 15)));
                issued++;
                continue;
            end else begin
                r = $urandom_range(0, 99);
                if (grow)
                    op = (r < 35) ? MODE_APPEND : (r < 65) ? MODE_INSERT :
                         (r < 75) ? MODE_REMOVE : (r < 80) ? MODE_DROP : MODE_READ;
                else
                    op = (r < 10) ? MODE_APPEND : (r < 20) ? MODE_INSERT :
                         (r < 55) ? MODE_REMOVE : (r < 75) ? MODE_DROP : MODE_READ;
            end
            push_op(op, pick_value(), pick_pos());
            issued++;
        end
        calm = 1'b0;

        drain();
        repeat (4) @(negedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
design/olir_pkg.sv
design/olir_cell.sv
design/ordered_list_insert_remove.sv
design/olir_checker.sv
tb/list_result_checker.sv
tb/tb_ordered_list_insert_remove.sv
